/* hdl/desm_pkg.sv */
`default_nettype none

package desm_pkg;

    // Field widths.
    localparam int ACTION_W = 2;
    localparam int CHAR_W   = 8;
    localparam int VALUE_W  = 32;
    localparam int SUM_W    = 34;
    localparam int COUNT_W  = 2;

    // Default depth of the character buffer.
    localparam int DEFAULT_BUFFER_DEPTH = 32;

    // Entries in the history and in the command queue.
    localparam int HIST_DEPTH  = 3;
    localparam int QUEUE_DEPTH = 2;

    // Action codes of an input beat.
    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_COMMIT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

    // Characters the parser classifies.
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR      = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;

    // Magnitude saturation point and the two saturated results.
    localparam logic [VALUE_W-1:0] MAG_CAP   = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;

    // Command passed from the parser to the history unit.
    typedef enum logic {
        CMD_PUSH,
        CMD_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [VALUE_W-1:0] value;
    } cmd_t;

endpackage

`default_nettype wire

/* hdl/desm_front.sv */
`default_nettype none

module desm_front #(
    parameter int BUFFER_DEPTH = desm_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [desm_pkg::ACTION_W-1:0]   action,
    input  wire logic [desm_pkg::CHAR_W-1:0]     char_code,
    output logic                                 push_valid,
    input  wire logic                            push_ready,
    output desm_pkg::cmd_t                       push_cmd
);
    import desm_pkg::*;

    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(BUFFER_DEPTH);
    localparam int PROD_W = VALUE_W + 4;

    typedef enum logic [1:0] {
        PHASE_LEAD,
        PHASE_NUM,
        PHASE_STOP
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic               neg_reg, neg_next;
    logic [VALUE_W-1:0] mag_reg, mag_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic               accept;
    logic               is_digit;
    logic               is_space;
    logic               is_sign;
    logic [PROD_W-1:0]  mag_times_ten;
    logic [VALUE_W-1:0] mag_with_digit;
    logic [VALUE_W-1:0] value;

    // Every beat waits for room in the queue so that commands keep their order.
    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;

    // Character classes.
    assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    assign is_space = (char_code == CHAR_SPACE)
                   || ((char_code >= CHAR_TAB) && (char_code <= CHAR_CR));
    assign is_sign  = (char_code == CHAR_PLUS) || (char_code == CHAR_MINUS);

    // Multiply by ten as two shifts and an add, then saturate at the cap.
    assign mag_times_ten = (PROD_W'(mag_reg) << 3) + (PROD_W'(mag_reg) << 1)
                         + PROD_W'(char_code - CHAR_ZERO);
    assign mag_with_digit = (mag_times_ten >= PROD_W'(MAG_CAP)) ? MAG_CAP
                                                                : mag_times_ten[VALUE_W-1:0];

    // Signed, saturated value of the current parse.
    always_comb
    begin
        if (mag_reg[VALUE_W-1])
        begin
            value = neg_reg ? VALUE_MIN : VALUE_MAX;
        end
        else
        begin
            value = neg_reg ? (~mag_reg + 1'b1) : mag_reg;
        end
    end

    // Commit and clear become commands for the history unit.
    assign push_valid     = in_valid && ((action == ACT_COMMIT) || (action == ACT_CLEAR));
    assign push_cmd.kind  = (action == ACT_COMMIT) ? CMD_PUSH : CMD_CLEAR;
    assign push_cmd.value = value;

    // Parse state update.
    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        cnt_next   = cnt_reg;
        if (accept)
        begin
            if ((action == ACT_COMMIT) || (action == ACT_CLEAR))
            begin
                phase_next = PHASE_LEAD;
                neg_next   = 1'b0;
                mag_next   = '0;
                cnt_next   = '0;
            end
            else if ((action == ACT_APPEND) && (cnt_reg < CNT_LIMIT))
            begin
                cnt_next = cnt_reg + 1'b1;
                unique case (phase_reg)
                    PHASE_LEAD:
                    begin
                        if (is_space)
                        begin
                            phase_next = PHASE_LEAD;
                        end
                        else if (is_sign)
                        begin
                            neg_next   = (char_code == CHAR_MINUS);
                            phase_next = PHASE_NUM;
                        end
                        else if (is_digit)
                        begin
                            mag_next   = mag_with_digit;
                            phase_next = PHASE_NUM;
                        end
                        else
                        begin
                            phase_next = PHASE_STOP;
                        end
                    end
                    PHASE_NUM:
                    begin
                        if (is_digit)
                        begin
                            mag_next = mag_with_digit;
                        end
                        else
                        begin
                            phase_next = PHASE_STOP;
                        end
                    end
                    PHASE_STOP:
                    begin
                        phase_next = PHASE_STOP;
                    end
                    default:
                    begin
                        phase_next = PHASE_STOP;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_LEAD;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            mag_reg   <= mag_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/desm_queue.sv */
`default_nettype none

module desm_queue (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push_valid,
    output logic            push_ready,
    input  wire desm_pkg::cmd_t push_cmd,
    output logic            pop_valid,
    input  wire logic       pop_ready,
    output desm_pkg::cmd_t  pop_cmd
);
    import desm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    // Pointers wrap at the depth, which is a power of two.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

/* hdl/desm_back.sv */
`default_nettype none

module desm_back (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  pop_valid,
    output logic                                       pop_ready,
    input  wire desm_pkg::cmd_t                        pop_cmd,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [desm_pkg::VALUE_W-1:0]        entered_value,
    output logic signed [desm_pkg::SUM_W-1:0]          history_sum,
    output logic signed [desm_pkg::VALUE_W-1:0]        history_median,
    output logic        [desm_pkg::COUNT_W-1:0]        history_count
);
    import desm_pkg::*;

    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(HIST_DEPTH);

    // History stage.
    logic signed [VALUE_W-1:0] hist_reg [HIST_DEPTH];
    logic [COUNT_W-1:0]        cnt_reg;
    logic                      s1_valid_reg;
    logic signed [VALUE_W-1:0] val_reg;

    // Output stage.
    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic signed [SUM_W-1:0]   out_sum_reg;
    logic signed [VALUE_W-1:0] out_median_reg;
    logic [COUNT_W-1:0]        out_count_reg;

    logic                      out_load;
    logic                      s1_load;
    logic                      do_pop;
    logic signed [SUM_W-1:0]   term1;
    logic signed [SUM_W-1:0]   term2;
    logic signed [SUM_W-1:0]   sum_next;
    logic signed [VALUE_W-1:0] hi;
    logic signed [VALUE_W-1:0] lo;
    logic signed [VALUE_W-1:0] median_next;

    // Each stage loads when it is empty or its content moves on this cycle.
    assign out_load  = !out_valid_reg || out_ready;
    assign s1_load   = !s1_valid_reg || out_load;
    assign pop_ready = s1_load;
    assign do_pop    = pop_valid && pop_ready;

    // Sum of the valid entries; the newest is always valid behind a push.
    assign term1    = (cnt_reg >= 2'd2) ? SUM_W'(hist_reg[1]) : '0;
    assign term2    = (cnt_reg == COUNT_FULL) ? SUM_W'(hist_reg[2]) : '0;
    assign sum_next = SUM_W'(hist_reg[0]) + term1 + term2;

    // Median of up to three signed entries; the larger one of two.
    assign hi = (hist_reg[0] > hist_reg[1]) ? hist_reg[0] : hist_reg[1];
    assign lo = (hist_reg[0] > hist_reg[1]) ? hist_reg[1] : hist_reg[0];

    always_comb
    begin
        if (cnt_reg <= 2'd1)
        begin
            median_next = hist_reg[0];
        end
        else if (cnt_reg == 2'd2)
        begin
            median_next = hi;
        end
        else if (hist_reg[2] >= hi)
        begin
            median_next = hi;
        end
        else if (hist_reg[2] <= lo)
        begin
            median_next = lo;
        end
        else
        begin
            median_next = hist_reg[2];
        end
    end

    // History stage control: a push shifts in a value, a clear empties the count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            cnt_reg      <= '0;
            hist_reg[0]  <= '0;
            hist_reg[1]  <= '0;
            hist_reg[2]  <= '0;
            val_reg      <= '0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= 1'b0;
            if (do_pop)
            begin
                unique case (pop_cmd.kind)
                    CMD_PUSH:
                    begin
                        s1_valid_reg <= 1'b1;
                        hist_reg[0]  <= pop_cmd.value;
                        hist_reg[1]  <= hist_reg[0];
                        hist_reg[2]  <= hist_reg[1];
                        val_reg      <= pop_cmd.value;
                        if (cnt_reg != COUNT_FULL)
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        cnt_reg <= '0;
                    end
                    default:
                    begin
                        cnt_reg <= cnt_reg;
                    end
                endcase
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && s1_valid_reg)
        begin
            out_value_reg  <= val_reg;
            out_sum_reg    <= sum_next;
            out_median_reg <= median_next;
            out_count_reg  <= cnt_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign entered_value  = out_value_reg;
    assign history_sum    = out_sum_reg;
    assign history_median = out_median_reg;
    assign history_count  = out_count_reg;

endmodule

`default_nettype wire

/* hdl/decimal_entry_sum_median3.sv */
`default_nettype none

// Decimal entry with a running sum and median of three. Each input beat carries
// an action: append a character, commit the number, or clear. Characters are
// parsed the way atoi does (leading whitespace skipped, one optional sign, stop
// at the first non-digit); characters beyond BUFFER_DEPTH are dropped. A commit
// yields one output beat with the value saturated to 32-bit signed, the exact sum
// and the median of the last one to three committed values, and their count.
// Append and clear yield no output beat. The block takes one input beat per
// cycle while the queue has room; the parser keeps its state in registers and
// hands commits and clears to the history unit through a two-entry queue. A
// commit's result passes through the queue entry, the history register and the
// output register in that order, and back-pressure on the output stalls the
// input only once the queue is full.
module decimal_entry_sum_median3 #(
    parameter int BUFFER_DEPTH = desm_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic        [desm_pkg::ACTION_W-1:0]  action,
    input  wire logic        [desm_pkg::CHAR_W-1:0]    char_code,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed      [desm_pkg::VALUE_W-1:0]   entered_value,
    output logic signed      [desm_pkg::SUM_W-1:0]     history_sum,
    output logic signed      [desm_pkg::VALUE_W-1:0]   history_median,
    output logic             [desm_pkg::COUNT_W-1:0]   history_count
);
    import desm_pkg::*;

    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    // Parser front end.
    desm_front #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .char_code  (char_code),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // Command queue between parser and history.
    desm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // History, sum and median.
    desm_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_cmd        (pop_cmd),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .entered_value  (entered_value),
        .history_sum    (history_sum),
        .history_median (history_median),
        .history_count  (history_count)
    );

`ifndef SYNTH
    // A result always covers at least the value just committed.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (history_count != '0))
        else $error("result beat with an empty history");

    // With one entry, sum and median both equal the committed value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (history_count == 2'd1)) |->
        ((history_median == entered_value)
         && (history_sum == SUM_W'(entered_value))))
        else $error("single-entry result does not match its value");

    // With two entries, the median is the larger one, so never below the newest.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (history_count == 2'd2)) |-> (history_median >= entered_value))
        else $error("two-entry median below the newest value");

    // An accepted commit or clear is waiting in the queue on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && ((action == ACT_COMMIT) || (action == ACT_CLEAR)))
        |=> pop_valid)
        else $error("command lost between parser and queue");
`endif

endmodule

`default_nettype wire

/* bench/desm_score_pkg.sv */
`default_nettype none

package desm_score_pkg;

    timeunit 1ns;
    timeprecision 1ps;

    import desm_pkg::*;

    // Action code that the block has to ignore.
    localparam logic [ACTION_W-1:0] ACT_IGNORED = 2'd3;

    // Progress of the number parse.
    typedef enum logic [1:0] {
        PH_LEAD,
        PH_NUM,
        PH_STOP
    } parse_phase_t;

    // One result beat as the block should present it.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic signed [SUM_W-1:0]   sum;
        logic signed [VALUE_W-1:0] median;
        logic        [COUNT_W-1:0] count;
    } entry_result_t;

    // Tracks the parse and the three-entry history, and checks the commit results.
    class entry_scoreboard;

        parse_phase_t              phase;
        bit                        neg;
        logic [VALUE_W-1:0]        mag;
        int unsigned               chars_taken;
        int unsigned               depth_limit;
        logic signed [VALUE_W-1:0] recent [HIST_DEPTH];
        int unsigned               filled;
        entry_result_t             expected_q [$];
        int unsigned               errors;

        function new(int unsigned buffer_depth);
            depth_limit = buffer_depth;
            restart_parse();
            foreach (recent[k])
                recent[k] = '0;
            filled = 0;
            errors = 0;
        endfunction

        function void restart_parse();
            phase = PH_LEAD;
            neg = 1'b0;
            mag = '0;
            chars_taken = 0;
        endfunction

        // Append one decimal digit; the magnitude saturates at 2^31.
        function void take_digit(logic [CHAR_W-1:0] ch);
            logic [63:0] grown;
            grown = {32'd0, mag} * 64'd10 + {56'd0, ch - CHAR_ZERO};
            mag = (grown >= {32'd0, MAG_CAP}) ? MAG_CAP : grown[VALUE_W-1:0];
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Update the prediction with an accepted input beat.
        function void note_beat(logic [ACTION_W-1:0] act, logic [CHAR_W-1:0] ch);
            logic                      is_digit;
            logic signed [VALUE_W-1:0] v;
            logic signed [VALUE_W-1:0] hi;
            logic signed [VALUE_W-1:0] lo;
            logic signed [VALUE_W-1:0] med;
            logic signed [SUM_W-1:0]   total;
            entry_result_t             res;
            int                        k;

            is_digit = (ch >= CHAR_ZERO && ch <= CHAR_NINE);
            case (act)
                ACT_APPEND:
                begin
                    // Characters past the buffer depth are dropped.
                    if (chars_taken < depth_limit)
                    begin
                        chars_taken++;
                        if (phase == PH_LEAD)
                        begin
                            if (ch == CHAR_SPACE || (ch >= CHAR_TAB && ch <= CHAR_CR))
                                phase = PH_LEAD;
                            else if (ch == CHAR_PLUS || ch == CHAR_MINUS)
                            begin
                                neg = (ch == CHAR_MINUS);
                                phase = PH_NUM;
                            end
                            else if (is_digit)
                            begin
                                take_digit(ch);
                                phase = PH_NUM;
                            end
                            else
                                phase = PH_STOP;
                        end
                        else if (phase == PH_NUM)
                        begin
                            if (is_digit)
                                take_digit(ch);
                            else
                                phase = PH_STOP;
                        end
                    end
                end
                ACT_CLEAR:
                begin
                    restart_parse();
                    filled = 0;
                end
                ACT_COMMIT:
                begin
                    // Saturate to 32-bit signed and push into the history.
                    if (neg)
                        v = (mag >= MAG_CAP) ? VALUE_MIN : -mag;
                    else
                        v = (mag >= MAG_CAP) ? VALUE_MAX : mag;
                    restart_parse();
                    recent[2] = recent[1];
                    recent[1] = recent[0];
                    recent[0] = v;
                    if (filled < HIST_DEPTH)
                        filled++;

                    total = '0;
                    for (k = 0; k < filled; k++)
                        total = total + {{2{recent[k][VALUE_W-1]}}, recent[k]};

                    // Median of the valid entries; the larger one when there are two.
                    hi = (recent[0] > recent[1]) ? recent[0] : recent[1];
                    lo = (recent[0] > recent[1]) ? recent[1] : recent[0];
                    if (filled == 1)
                        med = recent[0];
                    else if (filled == 2)
                        med = hi;
                    else if (recent[2] >= hi)
                        med = hi;
                    else if (recent[2] <= lo)
                        med = lo;
                    else
                        med = recent[2];

                    res.value  = v;
                    res.sum    = total;
                    res.median = med;
                    res.count  = filled[COUNT_W-1:0];
                    expected_q.push_back(res);
                end
                default:
                    ;
            endcase
        endfunction

        function void compare_field(string field, longint want, longint got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        // Compare an accepted result beat with the oldest expectation.
        function void check_result(logic signed [VALUE_W-1:0] value,
                                   logic signed [SUM_W-1:0]   sum,
                                   logic signed [VALUE_W-1:0] median,
                                   logic        [COUNT_W-1:0] count);
            entry_result_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual value %0d sum %0d",
                         $time, value, sum);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("entered_value", want.value, value);
            compare_field("history_sum", want.sum, sum);
            compare_field("history_median", want.median, median);
            compare_field("history_count", {62'd0, want.count}, {62'd0, count});
        endfunction

    endclass

endpackage

`default_nettype wire

/* bench/tb_top.sv */
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import desm_pkg::*;
    import desm_score_pkg::*;

    localparam int          BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH;
    localparam int          RANDOM_BEATS = 500;
    localparam int          HOLD_CYCLES  = 120;
    localparam int          DRAIN_CYCLES = 20;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [ACTION_W-1:0]       action = ACT_APPEND;
    logic [CHAR_W-1:0]         char_code = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [VALUE_W-1:0] entered_value;
    logic signed [SUM_W-1:0]   history_sum;
    logic signed [VALUE_W-1:0] history_median;
    logic [COUNT_W-1:0]        history_count;

    entry_scoreboard board;
    int unsigned     send_idle_pct = 0;
    int unsigned     recv_idle_pct = 0;
    int unsigned     hold_req = 0;
    int unsigned     hold_left = 0;
    int unsigned     beats_sent = 0;
    int unsigned     cycles = 0;

    decimal_entry_sum_median3 #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .char_code(char_code),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .entered_value(entered_value),
        .history_sum(history_sum),
        .history_median(history_median),
        .history_count(history_count)
    );

    always #5 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL decimal_entry_sum_median3");
            $finish;
        end
    end

    // Result side: check accepted beats, then pick the next ready level.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(entered_value, history_sum, history_median, history_count);
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Offer one input beat, with a random gap first, and wait until it is taken.
    task automatic send_beat(input logic [ACTION_W-1:0] act, input logic [CHAR_W-1:0] ch);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        char_code <= ch;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_beat(act, ch);
        beats_sent++;
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] ch);
        send_beat(ACT_APPEND, ch);
    endtask

    task automatic send_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++)
            send_char(s[k]);
    endtask

    // One random entry: mostly well-formed numbers, some clears, noise and stray characters.
    task automatic random_entry();
        int unsigned kind;
        int unsigned pad;
        int unsigned len;
        int unsigned k;
        string       lit;

        kind = $urandom_range(0, 99);
        if (kind < 4)
            send_beat(ACT_CLEAR, CHAR_W'($urandom_range(0, 255)));
        else if (kind < 8)
            send_beat(ACT_IGNORED, CHAR_W'($urandom_range(0, 255)));
        else if (kind < 11)
            send_char(CHAR_W'($urandom_range(0, 255)));
        else
        begin
            // Long whitespace runs bring the entry near or past the buffer depth.
            if (kind < 15)
                pad = $urandom_range(BUFFER_DEPTH - 4, BUFFER_DEPTH + 6);
            else
                pad = $urandom_range(0, 3);
            for (k = 0; k < pad; k++)
            begin
                if ($urandom_range(0, 1) == 0)
                    send_char(CHAR_SPACE);
                else
                    send_char(CHAR_TAB + CHAR_W'($urandom_range(0, 4)));
            end

            if (kind >= 15 && kind < 27)
            begin
                // Values at and past the 32-bit limits, and a negative zero.
                case ($urandom_range(0, 5))
                    0:       lit = "2147483647";
                    1:       lit = "2147483648";
                    2:       lit = "-2147483648";
                    3:       lit = "-2147483649";
                    4:       lit = "-0";
                    default: lit = "+4294967296";
                endcase
                send_text(lit);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       send_char(CHAR_PLUS);
                    1:       send_char(CHAR_MINUS);
                    default: ;
                endcase
                if ($urandom_range(0, 3) == 0)
                    len = $urandom_range(10, 12);
                else
                    len = $urandom_range(0, 9);
                for (k = 0; k < len; k++)
                    send_char(CHAR_ZERO + CHAR_W'($urandom_range(0, 9)));
                // A random character usually stops the parse; the digit after it is then ignored.
                if ($urandom_range(0, 4) == 0)
                begin
                    send_char(CHAR_W'($urandom_range(0, 255)));
                    send_char(CHAR_ZERO + CHAR_W'($urandom_range(0, 9)));
                end
            end
            send_beat(ACT_COMMIT, CHAR_W'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        board = new(BUFFER_DEPTH);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty commit, stop at a non-digit, negative overflow,
        // an ignored action code, then a clear followed by a fresh commit.
        send_beat(ACT_COMMIT, 8'hFF);
        send_text("+7");
        send_char(8'hFF);
        send_char(CHAR_NINE);
        send_beat(ACT_COMMIT, 8'h00);
        send_text("-99999999999");
        send_beat(ACT_COMMIT, 8'h00);
        send_beat(ACT_IGNORED, 8'h00);
        send_beat(ACT_CLEAR, 8'hFF);
        send_beat(ACT_COMMIT, 8'h00);

        // Random part in three idling phases; the last starts with a long receiver hold-off.
        beats_sent = 0;
        while (beats_sent < RANDOM_BEATS)
        begin
            if (beats_sent >= 2 * RANDOM_BEATS / 3)
            begin
                if (send_idle_pct != 0 || recv_idle_pct != 0)
                    hold_req = HOLD_CYCLES;
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (beats_sent >= RANDOM_BEATS / 3)
            begin
                send_idle_pct = 48;
                recv_idle_pct = 36;
            end
            else
            begin
                send_idle_pct = 36;
                recv_idle_pct = 48;
            end
            random_entry();
        end
        in_valid <= 1'b0;

        // Drain the remaining results, then watch for stray ones.
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.errors == 0)
            $display("PASS decimal_entry_sum_median3");
        else
            $display("FAIL decimal_entry_sum_median3");
        $finish;
    end

endmodule

`default_nettype wire
